/* rtl/psag_pkg.sv */
// Shared types, constants and step functions for the pixel sample average/gamma core.
// Used by psag_lane and pixel_sample_average_gamma_core; depends on nothing else.
package psag_pkg;

    localparam int IN_W     = 32;                    // width of an input sum port
    localparam int SUM_WIDTH = 32;                   // low bits of a sum that count
    localparam int EFF_W    = (SUM_WIDTH < IN_W) ? SUM_WIDTH : IN_W;
    localparam int SPP_W    = 16;                    // samples-per-pixel register width
    localparam int Q_W      = 16;                    // quotient bits kept (mean below 2^16)
    localparam int THR_W    = SPP_W + 16;            // width of spp * SAT_Q
    localparam int CMP_W    = (EFF_W > THR_W) ? EFF_W : THR_W;
    localparam int PX_W     = 8;
    localparam int RES_W    = Q_W + 1;               // root accumulator width

    localparam logic [PX_W-1:0] PX_MAX = {PX_W{1'b1}};
    // Any mean at or above 255^2 gives a saturated pixel.
    localparam logic [15:0] SAT_Q = 16'(int'(PX_MAX) * int'(PX_MAX));
    localparam logic [SPP_W-1:0] SPP_ONE = SPP_W'(1);

    localparam int DIV_PER_STG = 2;
    localparam int DIV_STG     = Q_W / DIV_PER_STG;
    localparam int SQ_STEPS    = Q_W / 2;
    localparam int SQ_PER_STG  = 2;
    localparam int SQ_STG      = SQ_STEPS / SQ_PER_STG;
    localparam int SQ_TOP      = 2 * (SQ_STEPS - 1);
    // capture stage, divide stages, root stages (last one holds the pixel)
    localparam int NUM_STG     = 1 + DIV_STG + SQ_STG;

    typedef logic [NUM_STG-1:0] t_stg_vec;

    typedef struct packed {
        logic           sat;
        logic [Q_W-1:0] rem;
        logic [Q_W-1:0] low;   // dividend bits still to shift in, quotient bits shift in
    } t_div;

    typedef struct packed {
        logic             sat;
        logic [Q_W-1:0]   v;
        logic [RES_W-1:0] res;
    } t_sq;

    // One restoring division step.
    function automatic t_div div_step(t_div s, logic [SPP_W-1:0] d);
        logic [Q_W:0] tmp;
        t_div         o;
        o   = s;
        tmp = {s.rem, s.low[Q_W-1]};
        if (tmp >= (Q_W+1)'(d)) begin
            o.rem = Q_W'(tmp - (Q_W+1)'(d));
            o.low = {s.low[Q_W-2:0], 1'b1};
        end else begin
            o.rem = tmp[Q_W-1:0];
            o.low = {s.low[Q_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [RES_W-1:0] sq_bit(int i);
        return RES_W'(1) << (SQ_TOP - 2 * i);
    endfunction

    // One digit of the bitwise integer square root.
    function automatic t_sq sq_step(t_sq s, logic [RES_W-1:0] b);
        logic [RES_W-1:0] tmp;
        t_sq              o;
        o   = s;
        tmp = s.res + b;
        if (RES_W'(s.v) >= tmp) begin
            o.v   = Q_W'(RES_W'(s.v) - tmp);
            o.res = (s.res >> 1) + b;
        end else begin
            o.res = s.res >> 1;
        end
        return o;
    endfunction

endpackage

/* rtl/psag_lane.sv */
// One color channel datapath: pipelined divide by spp, saturate, pipelined square root.
// Depends on psag_pkg; stage enables come from the control in the top level.
module psag_lane (
    input  logic                          i_clk,
    input  psag_pkg::t_stg_vec            i_en,
    input  logic [psag_pkg::EFF_W-1:0]    i_sum,
    input  logic [psag_pkg::SPP_W-1:0]    i_spp,
    input  logic [psag_pkg::THR_W-1:0]    i_thresh,
    output logic [psag_pkg::PX_W-1:0]     o_px
);
    import psag_pkg::*;

    t_div             r_div [DIV_STG+1];
    t_div             n_div [DIV_STG+1];
    t_sq              r_sq  [SQ_STG-1];
    t_sq              n_sq  [SQ_STG];
    logic [PX_W-1:0]  r_px;

    // Capture: a mean of 255^2 or more is flagged here, so only 16 quotient bits are needed.
    always_comb begin
        n_div[0].sat = CMP_W'(i_sum) >= CMP_W'(i_thresh);
        n_div[0].rem = Q_W'(CMP_W'(i_sum) >> Q_W);
        n_div[0].low = i_sum[Q_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_div[0] <= n_div[0];
        end
    end

    genvar k;
    generate
        for (k = 1; k <= DIV_STG; k++) begin : g_div
            always_comb begin
                n_div[k] = r_div[k-1];
                for (int s = 0; s < DIV_PER_STG; s++) begin
                    n_div[k] = div_step(n_div[k], i_spp);
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_div[k] <= n_div[k];
                end
            end
        end

        for (k = 0; k < SQ_STG; k++) begin : g_sq
            always_comb begin
                if (k == 0) begin
                    n_sq[k].sat = r_div[DIV_STG].sat;
                    n_sq[k].v   = r_div[DIV_STG].low;
                    n_sq[k].res = '0;
                end else begin
                    n_sq[k] = r_sq[(k == 0) ? 0 : k-1];
                end
                for (int s = 0; s < SQ_PER_STG; s++) begin
                    n_sq[k] = sq_step(n_sq[k], sq_bit(k * SQ_PER_STG + s));
                end
            end

            if (k < SQ_STG - 1) begin : g_reg
                always_ff @(posedge i_clk) begin
                    if (i_en[1 + DIV_STG + k]) begin
                        r_sq[k] <= n_sq[k];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en[NUM_STG-1]) begin
            r_px <= n_sq[SQ_STG-1].sat ? PX_MAX : PX_W'(n_sq[SQ_STG-1].res);
        end
    end

    assign o_px = r_px;

    // A saturated item always leaves as full scale.
    property p_sat_out;
        @(posedge i_clk) i_en[NUM_STG-1] && n_sq[SQ_STG-1].sat |=> r_px == PX_MAX;
    endproperty
    a_sat_out: assert property (p_sat_out) else $error("saturated item not at full scale");

    // Without saturation the quotient stays below 255^2, so the root fits in 8 bits.
    property p_root_fits;
        @(posedge i_clk) i_en[NUM_STG-1] && !n_sq[SQ_STG-1].sat
            |-> n_sq[SQ_STG-1].res <= RES_W'(PX_MAX);
    endproperty
    a_root_fits: assert property (p_root_fits) else $error("root out of range");

    // The high half of an unsaturated sum is below the divisor.
    property p_rem_bound;
        @(posedge i_clk) !n_div[0].sat && i_spp != '0 |-> n_div[0].rem < i_spp;
    endproperty
    a_rem_bound: assert property (p_rem_bound) else $error("division would overflow");

endmodule

/* rtl/pixel_sample_average_gamma_core.sv */
// Top level: config register, pipeline valid/ready control, three channel lanes.
// Depends on psag_pkg and psag_lane.
// One item per cycle sustained while i_stall is low.
// The pipeline is 13 register stages: capture, 8 divide stages (2 quotient bits each),
// 4 square root stages (2 root bits each, the last holds the pixel).
// Bubbles collapse: a stage loads whenever it is empty or the stage after it moves.
// Synchronous active-low reset empties the pipeline and sets samples-per-pixel to 1.
module pixel_sample_average_gamma_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [psag_pkg::SPP_W-1:0]    i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [psag_pkg::IN_W-1:0]     i_red_sum,
    input  logic [psag_pkg::IN_W-1:0]     i_green_sum,
    input  logic [psag_pkg::IN_W-1:0]     i_blue_sum,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [psag_pkg::PX_W-1:0]     o_red_out,
    output logic [psag_pkg::PX_W-1:0]     o_green_out,
    output logic [psag_pkg::PX_W-1:0]     o_blue_out
);
    import psag_pkg::*;

    logic [SPP_W-1:0] r_spp;
    logic [SPP_W-1:0] n_spp;
    logic [THR_W-1:0] r_thresh;
    t_stg_vec         r_vld;
    t_stg_vec         en;

    // A count of zero means one.
    assign n_spp = (i_cfg_wdata == '0) ? SPP_ONE : i_cfg_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spp    <= SPP_ONE;
            r_thresh <= THR_W'(SAT_Q);
        end else if (i_cfg_we) begin
            r_spp    <= n_spp;
            r_thresh <= THR_W'(n_spp) * THR_W'(SAT_Q);
        end
    end

    // Ready chain from the output back to the input.
    always_comb begin
        en[NUM_STG-1] = !r_vld[NUM_STG-1] || !i_stall;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NUM_STG-1];

    psag_lane u_red (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_sum    (i_red_sum[EFF_W-1:0]),
        .i_spp    (r_spp),
        .i_thresh (r_thresh),
        .o_px     (o_red_out)
    );

    psag_lane u_green (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_sum    (i_green_sum[EFF_W-1:0]),
        .i_spp    (r_spp),
        .i_thresh (r_thresh),
        .o_px     (o_green_out)
    );

    psag_lane u_blue (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_sum    (i_blue_sum[EFF_W-1:0]),
        .i_spp    (r_spp),
        .i_thresh (r_thresh),
        .o_px     (o_blue_out)
    );

    property p_spp_nonzero;
        @(posedge i_clk) disable iff (!i_rst_n) r_spp != '0;
    endproperty
    a_spp_nonzero: assert property (p_spp_nonzero) else $error("divisor is zero");

    property p_thresh_match;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_thresh == THR_W'(r_spp) * THR_W'(SAT_Q);
    endproperty
    a_thresh_match: assert property (p_thresh_match) else $error("threshold out of step");

    // A held stage keeps its item.
    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            1'b1 |=> (($past(r_vld) & ~$past(en)) & ~r_vld) == '0;
    endproperty
    a_hold: assert property (p_hold) else $error("item dropped in a held stage");

    property p_no_false_stall;
        @(posedge i_clk) disable iff (!i_rst_n) !r_vld[0] |-> !o_stall;
    endproperty
    a_no_false_stall: assert property (p_no_false_stall) else $error("stall with empty entry");

endmodule
